FILE: rtl/spa_pkg.sv
// Package: shared request codes, status codes and result type of the slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;

  localparam int unsigned POOL_SLOTS_DEFAULT = 256;
  localparam int unsigned SLOT_W             = 8;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] ST_NOT_ISSUED  = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        status;
    logic              is_free;
  } spa_result_t;

endpackage
`default_nettype wire

FILE: rtl/spa_stack_ram.sv
// Freed-slot stack memory: one write port, one registered write-first read port.
`timescale 1ns / 1ps
`default_nettype none
module spa_stack_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spa_engine.sv
// Allocator state and decision logic: free marks, stack top, stack count, fresh pointer.
`timescale 1ns / 1ps
`default_nettype none
module spa_engine #(
  parameter int unsigned POOL_SLOTS = spa_pkg::POOL_SLOTS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     fire,
  input  wire logic [1:0]               req_type,
  input  wire logic [spa_pkg::SLOT_W-1:0] slot,
  output spa_pkg::spa_result_t          result
);
  import spa_pkg::*;

  localparam int unsigned DEPTH  = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned FRESH_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned CMP_W  = (FRESH_W > SLOT_W) ? FRESH_W : SLOT_W;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [FRESH_W-1:0] fresh;
  logic [FRESH_W-1:0] fresh_next;
  logic [ADDR_W-1:0]  top;
  logic [ADDR_W-1:0]  top_next;
  logic [DEPTH-1:0]   mark;
  logic [DEPTH-1:0]   mark_next;
  logic [ADDR_W-1:0]  second;
  logic               push;
  logic [CNT_W-1:0]   raddr_full;
  logic [CNT_W-1:0]   waddr_full;
  logic [ADDR_W-1:0]  slot_idx;

  assign slot_idx   = slot[ADDR_W-1:0];
  assign raddr_full = count_next - CNT_W'(2);
  assign waddr_full = count - CNT_W'(1);

  always_comb begin
    count_next = count;
    fresh_next = fresh;
    top_next   = top;
    mark_next  = mark;
    push       = 1'b0;
    result     = '0;
    unique case (req_type)
      REQ_ALLOC: begin
        if (count != '0) begin
          result.granted_slot = SLOT_W'(top);
          mark_next[top]      = 1'b0;
          count_next          = count - CNT_W'(1);
          top_next            = second;
        end else if (fresh < FRESH_W'(POOL_SLOTS)) begin
          result.granted_slot = SLOT_W'(fresh);
          if (fresh < FRESH_W'(DEPTH)) begin
            mark_next[fresh[ADDR_W-1:0]] = 1'b0;
          end
          fresh_next = fresh + FRESH_W'(1);
        end else begin
          result.status = ST_EXHAUSTED;
        end
      end
      REQ_FREE: begin
        if (CMP_W'(slot) >= CMP_W'(fresh)) begin
          result.status = ST_NOT_ISSUED;
        end else if (mark[slot_idx]) begin
          result.status = ST_DOUBLE_FREE;
        end else if (count < CNT_W'(DEPTH)) begin
          mark_next[slot_idx] = 1'b1;
          push                = 1'b1;
          top_next            = slot_idx;
          count_next          = count + CNT_W'(1);
        end
      end
      REQ_QUERY: begin
        if (CMP_W'(slot) < CMP_W'(DEPTH)) begin
          result.is_free = mark[slot_idx];
        end
      end
      default: begin
        result = '0;
      end
    endcase
    if (!fire) begin
      count_next = count;
      fresh_next = fresh;
      top_next   = top;
      mark_next  = mark;
      push       = 1'b0;
    end
  end

  spa_stack_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ADDR_W)
  ) u_stack (
    .clk   (clk),
    .we    (push && (count != '0)),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (top),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fresh <= '0;
      mark  <= '0;
    end else begin
      count <= count_next;
      fresh <= fresh_next;
      mark  <= mark_next;
    end
    top <= top_next;
  end

endmodule
`default_nettype wire

FILE: rtl/slot_pool_allocator_core.sv
// Top level: input register, allocator engine and result register of the slot pool allocator.
// Path: the input register captures a request and the engine decides it; the result
// register holds the result, registered together with the engine's new state.
// Throughput: one request per cycle unless a result held with out_ready low stalls input.
// Reset: synchronous active-high rst empties the stack, rewinds the fresh-slot pointer
// and clears every free mark; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none
module slot_pool_allocator_core #(
  parameter int unsigned POOL_SLOTS = spa_pkg::POOL_SLOTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 req_type,
  input  wire logic [spa_pkg::SLOT_W-1:0] slot,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [spa_pkg::SLOT_W-1:0]      granted_slot,
  output logic [1:0]                      status,
  output logic                            is_free
);
  import spa_pkg::*;

  logic              s1_valid;
  logic [1:0]        s1_req;
  logic [SLOT_W-1:0] s1_slot;
  logic              s1_adv;
  logic              fire;
  spa_result_t       res;
  spa_result_t       res_q;

  assign s1_adv   = !out_valid || out_ready;
  assign fire     = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  spa_engine #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (s1_req),
    .slot     (s1_slot),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
    if (in_valid && in_ready) begin
      s1_req  <= req_type;
      s1_slot <= slot;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign granted_slot = res_q.granted_slot;
  assign status       = res_q.status;
  assign is_free      = res_q.is_free;

endmodule
`default_nettype wire
